// ===== src/bhpv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bhpv_pkg;

  typedef enum logic [2:0] {
    ST_MATCH    = 3'd0,
    ST_MISMATCH = 3'd1,
    ST_EQUAL    = 3'd2,
    ST_ZERO     = 3'd3,
    ST_LIMIT    = 3'd4
  } status_t;

  // Classified job handed from the front part to the back part.
  typedef struct packed {
    logic [31:0] nonce_a;
    logic [31:0] nonce_b;
    logic        early;
    status_t     status;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_ROUND,
    BK_FINAL,
    BK_OUT
  } back_state_t;

  localparam int unsigned ROUNDS   = 80;
  localparam int unsigned CFG_REGS = 4;

  localparam logic [63:0] IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  function automatic logic [63:0] round_k(input logic [6:0] idx);
    logic [63:0] k;
    case (idx)
      7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
      7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
      7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
      7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
      7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = 64'h0;
    endcase
    return k;
  endfunction

  function automatic logic [63:0] bswap64(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = x[8*(7-i) +: 8];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/bhpv_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bhpv_front
  import bhpv_pkg::*;
#(
  parameter logic [31:0] NONCE_LIMIT = 32'd67108864
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] nonce_a,
  input  wire logic [31:0] nonce_b,
  output logic             job_valid,
  input  wire logic        job_ready,
  output job_t             job
);

  // Two-entry queue between classification and hashing.
  job_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  job_t       cls;
  logic       push, pop;

  always_comb begin
    cls.nonce_a = nonce_a;
    cls.nonce_b = nonce_b;
    cls.early   = 1'b1;
    if (nonce_a == nonce_b) begin
      cls.status = ST_EQUAL;
    end else if (nonce_a == 32'd0 || nonce_b == 32'd0) begin
      cls.status = ST_ZERO;
    end else if (nonce_a > NONCE_LIMIT || nonce_b > NONCE_LIMIT) begin
      cls.status = ST_LIMIT;
    end else begin
      cls.status = ST_MATCH;
      cls.early  = 1'b0;
    end
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign job_valid = (cnt_r != 2'd0);
  assign pop       = job_valid && job_ready;
  assign job       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ===== src/bhpv_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bhpv_back
  import bhpv_pkg::*;
#(
  parameter int unsigned BIRTHDAY_BITS = 50
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     job_valid,
  output logic                          job_ready,
  input  wire job_t                     job,
  input  wire logic [255:0]             seed,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [2:0]                    status,
  output logic [BIRTHDAY_BITS-1:0]      birthday_a,
  output logic [BIRTHDAY_BITS-1:0]      birthday_b
);

  back_state_t       st_r, st_nxt;
  logic [6:0]        rnd_r;
  logic              second_r;
  job_t              job_r;
  logic [63:0]       w_r [16];
  logic [63:0]       a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [BIRTHDAY_BITS-1:0] ba_r, bb_r;
  logic [2:0]        status_r;

  logic [31:0]  cur_nonce;
  logic [63:0]  msg [16];
  logic [63:0]  t1, t2, s0, s1, w_new, dig, word;
  logic [63:0]  h_fin [8];

  assign cur_nonce = second_r ? job_r.nonce_b : job_r.nonce_a;

  // Message block: nonce base then seed bytes, all byte-serial big-endian words.
  always_comb begin
    logic [8*128-1:0] blk;
    blk = '0;
    blk[8*128-1 -: 32] = {cur_nonce[7:3], 3'b000, cur_nonce[15:8], cur_nonce[23:16],
                          cur_nonce[31:24]};
    for (int i = 0; i < 32; i++) begin
      blk[8*128-1-32-8*i -: 8] = seed[8*i +: 8];
    end
    blk[8*128-1-8*36 -: 8] = 8'h80;
    blk[15:0] = 16'd288;
    for (int i = 0; i < 16; i++) begin
      msg[i] = blk[8*128-1-64*i -: 64];
    end
  end

  always_comb begin
    s0 = {w_r[1][0], w_r[1][63:1]} ^ {w_r[1][7:0], w_r[1][63:8]} ^ (w_r[1] >> 7);
    s1 = {w_r[14][18:0], w_r[14][63:19]} ^ {w_r[14][60:0], w_r[14][63:61]} ^ (w_r[14] >> 6);
    w_new = w_r[0] + s0 + w_r[9] + s1;
    t1 = h_r + ({e_r[13:0], e_r[63:14]} ^ {e_r[17:0], e_r[63:18]} ^ {e_r[40:0], e_r[63:41]})
         + ((e_r & f_r) ^ (~e_r & g_r)) + round_k(rnd_r) + w_r[0];
    t2 = ({a_r[27:0], a_r[63:28]} ^ {a_r[33:0], a_r[63:34]} ^ {a_r[38:0], a_r[63:39]})
         + ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));
    h_fin[0] = IV[0] + a_r; h_fin[1] = IV[1] + b_r;
    h_fin[2] = IV[2] + c_r; h_fin[3] = IV[3] + d_r;
    h_fin[4] = IV[4] + e_r; h_fin[5] = IV[5] + f_r;
    h_fin[6] = IV[6] + g_r; h_fin[7] = IV[7] + h_r;
    dig  = h_fin[cur_nonce[2:0]];
    word = bswap64(dig) >> (64 - BIRTHDAY_BITS);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE:  if (job_valid) st_nxt = job.early ? BK_OUT : BK_LOAD;
      BK_LOAD:  st_nxt = BK_ROUND;
      BK_ROUND: if (rnd_r == 7'(ROUNDS - 1)) st_nxt = BK_FINAL;
      BK_FINAL: st_nxt = second_r ? BK_OUT : BK_LOAD;
      BK_OUT:   if (out_ready) st_nxt = BK_IDLE;
      default:  st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    job_ready = (st_r == BK_IDLE);
    out_valid = (st_r == BK_OUT);
  end

  assign status     = status_r;
  assign birthday_a = ba_r;
  assign birthday_b = bb_r;

  always_ff @(posedge clk) begin
    case (st_r)
      BK_IDLE: begin
        job_r    <= job;
        status_r <= job.status;
        ba_r     <= '0;
        bb_r     <= '0;
      end
      BK_LOAD: begin
        for (int i = 0; i < 16; i++) w_r[i] <= msg[i];
        a_r <= IV[0]; b_r <= IV[1]; c_r <= IV[2]; d_r <= IV[3];
        e_r <= IV[4]; f_r <= IV[5]; g_r <= IV[6]; h_r <= IV[7];
      end
      BK_ROUND: begin
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= w_new;
        h_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
        d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
      end
      BK_FINAL: begin
        if (second_r) begin
          bb_r     <= word[BIRTHDAY_BITS-1:0];
          status_r <= (ba_r == word[BIRTHDAY_BITS-1:0]) ? ST_MATCH : ST_MISMATCH;
        end else begin
          ba_r <= word[BIRTHDAY_BITS-1:0];
        end
      end
      default: ;
    endcase
    if (!rst_n) begin
      st_r     <= BK_IDLE;
      rnd_r    <= '0;
      second_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        BK_IDLE:  second_r <= 1'b0;
        BK_LOAD:  rnd_r <= '0;
        BK_ROUND: rnd_r <= rnd_r + 7'd1;
        BK_FINAL: second_r <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/birthday_hash_pair_verify.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Verifies a nonce pair against a 256-bit seed held in four 64-bit registers
// (byte addresses 0, 8, 16, 24). A front stage checks for equal, zero and
// over-limit nonces and queues the pair; a back stage runs SHA-512 on one
// shared round unit, one round per cycle. A pair that needs hashing goes
// through two compressions of 80 rounds, each with a load and a finish step;
// an early-rejected pair goes straight to the result. One result beat per pair.
module birthday_hash_pair_verify
  import bhpv_pkg::*;
#(
  parameter logic [31:0] NONCE_LIMIT   = 32'd67108864,
  parameter int unsigned BIRTHDAY_BITS = 50
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [63:0]  in_tdata,   // nonce_a [31:0], nonce_b [63:32]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // status [2:0], birthday_a, birthday_b, zero fill
  output logic [((3 + 2 * BIRTHDAY_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [4:0]   cfg_paddr,
  input  wire logic [63:0]  cfg_pwdata,
  output logic [63:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [63:0] seed_r [CFG_REGS];
  logic        job_valid, job_ready;
  job_t        job;
  logic [2:0]  status;
  logic [BIRTHDAY_BITS-1:0] bda, bdb;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2:0] == 3'd0) ? seed_r[cfg_paddr[4:3]] : 64'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CFG_REGS; i++) seed_r[i] <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2:0] == 3'd0) begin
      seed_r[cfg_paddr[4:3]] <= cfg_pwdata;
    end
  end

  bhpv_front #(.NONCE_LIMIT(NONCE_LIMIT)) u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .nonce_a(in_tdata[31:0]), .nonce_b(in_tdata[63:32]),
    .job_valid, .job_ready, .job
  );

  bhpv_back #(.BIRTHDAY_BITS(BIRTHDAY_BITS)) u_back (
    .clk, .rst_n, .job_valid, .job_ready, .job,
    .seed({seed_r[3], seed_r[2], seed_r[1], seed_r[0]}),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .status, .birthday_a(bda), .birthday_b(bdb)
  );

  always_comb begin
    out_tdata = '0;
    out_tdata[2:0] = status;
    out_tdata[3 +: BIRTHDAY_BITS] = bda;
    out_tdata[3 + BIRTHDAY_BITS +: BIRTHDAY_BITS] = bdb;
  end

endmodule
`default_nettype wire
